// ===== hw/rtl/smaq_pkg.sv =====
package smaq_pkg;

  localparam int unsigned DefCapacity = 4096;
  localparam int unsigned ValW = 31;

  typedef struct packed {
    logic            kind;
    logic [ValW-1:0] operand;
  } smaq_in_t;

  typedef struct packed {
    logic [ValW-1:0] max_value;
    logic            length_clamped;
  } smaq_out_t;

  localparam logic KindAppend = 1'b0;
  localparam logic KindQuery  = 1'b1;

endpackage

// ===== hw/rtl/suffix_max_append_query_top.sv =====
// Suffix maximum over an append-only list, kept in a max segment tree.
// Input channel in_valid/in_ready carries one item: kind 0 appends
// (last answer + operand) mod modulus, kind 1 asks for the maximum of the
// last operand values. Queries give one item on out_valid/out_ready;
// appends give none. Appends beyond CAPACITY are dropped.
// modulus is to be written through cfg_we/cfg_wdata only while idle; the
// block itself does not enforce this. 0 acts as 2^31. The block takes one
// item at a time. An append runs a restoring division (one remainder bit a
// cycle), a leaf write, then per level a sibling read, a compare and a
// parent write, using the memory's one read port and one write port. A query
// walks the tree from both ends; a query on an empty list is answered
// straight from the idle state without a walk. After reset a clearing pass
// zeroes all 2^(clog2(CAPACITY)+1) tree memory words, one per cycle;
// in_ready stays low meanwhile. The result waits in an output register;
// while out_valid is high and not taken, no new item is accepted.
module suffix_max_append_query_top #(
  parameter int unsigned CAPACITY = smaq_pkg::DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  smaq_pkg::smaq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smaq_pkg::smaq_out_t out_data,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata
);
  import smaq_pkg::*;

  localparam int unsigned LW = $clog2(CAPACITY);
  localparam int unsigned AW = LW + 1;
  localparam int unsigned CW = LW + 1;
  localparam int unsigned HW = AW + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_UPR  = 4'd3;
  localparam logic [3:0] S_UPW  = 4'd4;
  localparam logic [3:0] S_QRD  = 4'd5;
  localparam logic [3:0] S_QLO  = 4'd6;
  localparam logic [3:0] S_QHI  = 4'd7;
  localparam logic [3:0] S_QHW  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [ValW-1:0] mem [2**AW];
  logic [ValW-1:0] rdata;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [ValW-1:0] wdata;

  logic [3:0]      state;
  logic [AW-1:0]   clr;
  logic [ValW-1:0] modulus;
  logic [CW-1:0]   count;
  logic [ValW-1:0] last_answer;
  logic [ValW:0]   rem;
  logic [32:0]     sum;
  logic [5:0]      bitc;
  logic [AW-1:0]   node;
  logic [HW-1:0]   lo, hi;
  logic [ValW-1:0] cur, best;
  logic            clamped;

  logic [31:0]     divisor;
  logic [32:0]     trial;
  logic [HW-1:0]   hi_dec;

  assign divisor = (modulus == '0) ? 32'h8000_0000 : {1'b0, modulus};
  assign trial   = {rem, sum[32]} - {1'b0, divisor};
  assign hi_dec  = hi - HW'(1);
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = node;
    wdata = cur;
    raddr = node;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      S_UPR:   raddr = node ^ AW'(1);
      S_UPW: begin
        we = 1'b1;
      end
      S_QRD: begin
        if (lo[0]) raddr = lo[AW-1:0];
        else raddr = hi_dec[AW-1:0];
      end
      S_QHI:   raddr = hi_dec[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr         <= '0;
      modulus     <= 31'h7FFF_FFFF;
      count       <= '0;
      last_answer <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) modulus <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + AW'(1);
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_data.kind == KindAppend) begin
              if (count != CW'(CAPACITY)) begin
                sum   <= {2'b0, last_answer} + {2'b0, in_data.operand};
                rem   <= '0;
                bitc  <= '0;
                state <= S_DIV;
              end
            end else if (count == '0) begin
              out_data.max_value      <= '0;
              out_data.length_clamped <= 1'b1;
              last_answer             <= '0;
              out_valid               <= 1'b1;
            end else begin
              best    <= '0;
              hi      <= HW'(CAPACITY) + HW'(count);
              if (in_data.operand == '0) begin
                clamped <= 1'b1;
                lo      <= HW'(CAPACITY) + HW'(count) - HW'(1);
              end else if (in_data.operand > ValW'(count)) begin
                clamped <= 1'b1;
                lo      <= HW'(CAPACITY);
              end else begin
                clamped <= 1'b0;
                lo      <= HW'(CAPACITY) + HW'(count) - HW'(in_data.operand);
              end
              state <= S_QRD;
            end
          end
        end
        S_DIV: begin
          if (!trial[32]) rem <= trial[31:0];
          else rem <= {rem[30:0], sum[32]};
          sum  <= {sum[31:0], 1'b0};
          bitc <= bitc + 6'd1;
          if (bitc == 6'd32) begin
            node  <= AW'(CAPACITY) + AW'(count);
            state <= S_UPW;
          end
        end
        S_UPW: begin
          if (node == AW'(CAPACITY) + AW'(count) && bitc == 6'd33) begin
            bitc <= '0;
          end
          if (node == AW'(1)) begin
            count <= count + CW'(1);
            state <= S_IDLE;
          end else state <= S_UPR;
        end
        S_UPR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rdata > cur) cur <= rdata;
          node  <= node >> 1;
          state <= S_UPW;
        end
        S_QRD: begin
          if (lo >= hi) begin
            out_data.max_value      <= best;
            out_data.length_clamped <= clamped;
            last_answer             <= best;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end else if (lo[0]) state <= S_QLO;
          else if (hi[0]) state <= S_QHW;
          else begin
            lo <= lo >> 1;
            hi <= hi >> 1;
          end
        end
        S_QLO: begin
          if (rdata > best) best <= rdata;
          if (hi[0]) begin
            lo    <= lo + HW'(1);
            state <= S_QHI;
          end else begin
            lo    <= (lo + HW'(1)) >> 1;
            hi    <= hi >> 1;
            state <= S_QRD;
          end
        end
        S_QHI: state <= S_QHW;
        S_QHW: begin
          if (rdata > best) best <= rdata;
          lo    <= lo >> 1;
          hi    <= hi_dec >> 1;
          state <= S_QRD;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && bitc == 6'd32) begin
        cur <= (!trial[32]) ? trial[ValW-1:0] : {rem[29:0], sum[32]};
      end
    end
  end

endmodule

// ===== tb/smaq_checker.sv =====
module smaq_checker #(
  parameter int unsigned CAPACITY = smaq_pkg::DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  smaq_pkg::smaq_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  smaq_pkg::smaq_out_t out_data,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending
);
  import smaq_pkg::*;

  logic [ValW-1:0] values[CAPACITY];
  int unsigned     n_stored;
  logic [ValW-1:0] last_max;
  logic [ValW-1:0] modulus;
  smaq_out_t       expected_q[$];

  function automatic logic [ValW-1:0] append_value(logic [ValW-1:0] x);
    logic [32:0] sum;
    logic [32:0] div;
    sum = {2'b0, last_max} + {2'b0, x};
    div = (modulus == '0) ? 33'h080000000 : {2'b0, modulus};
    return ValW'(sum % div);
  endfunction

  function automatic smaq_out_t query_max(logic [ValW-1:0] len_req);
    smaq_out_t r;
    int unsigned len;
    r.max_value = '0;
    r.length_clamped = 1'b0;
    len = len_req;
    if (n_stored == 0) begin
      r.length_clamped = 1'b1;
    end else begin
      if (len == 0) begin
        len = 1;
        r.length_clamped = 1'b1;
      end else if (len > n_stored) begin
        len = n_stored;
        r.length_clamped = 1'b1;
      end
      for (int unsigned i = n_stored - len; i < n_stored; i++)
        if (values[i] > r.max_value) r.max_value = values[i];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    smaq_out_t e;
    int errs;
    errs = 0;
    if (rst) begin
      n_stored <= 0;
      last_max <= '0;
      modulus <= 31'h7FFFFFFF;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) modulus <= cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_data.kind == KindAppend) begin
          if (n_stored < CAPACITY) begin
            values[n_stored] = append_value(in_data.operand);
            n_stored <= n_stored + 1;
          end
        end else begin
          e = query_max(in_data.operand);
          last_max <= e.max_value;
          expected_q.push_back(e);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with none expected");
          errs = errs + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_data.max_value !== e.max_value) begin
            $error("max_value expected %0d actual %0d", e.max_value, out_data.max_value);
            errs = errs + 1;
          end
          if (out_data.length_clamped !== e.length_clamped) begin
            $error("length_clamped expected %0d actual %0d",
                   e.length_clamped, out_data.length_clamped);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending = expected_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
module testbench;
  import smaq_pkg::*;

  localparam int unsigned Capacity = DefCapacity;
  localparam int CycleLimit = 3000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  smaq_in_t in_data;
  logic out_valid;
  logic out_ready;
  smaq_out_t out_data;
  logic cfg_we;
  logic [30:0] cfg_wdata;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  int n_appends;

  suffix_max_append_query_top #(.CAPACITY(Capacity)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  smaq_checker #(.CAPACITY(Capacity)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic kind, logic [30:0] operand);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.kind <= kind;
    in_data.operand <= operand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KindAppend) n_appends++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_modulus(logic [30:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [30:0] rand_operand();
    case ($urandom_range(3))
      0: return 31'($urandom_range(7));
      1: return 31'h7FFFFFFF - 31'($urandom_range(3));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [30:0] rand_length();
    case ($urandom_range(4))
      0: return 31'd0;
      1: return 31'($urandom_range(n_appends + 2));
      2: return 31'($urandom());
      default: return 31'($urandom_range(16, 1));
    endcase
  endfunction

  initial begin
    logic [30:0] moduli[5];
    moduli = '{31'd0, 31'd1, 31'd1000, 31'h7FFFFFFF, 31'h7FFFFFFE};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 20;
    recv_idle_pct = 81;
    n_appends = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, operand extremes, clamps
    send_item(KindQuery, 31'd0);
    send_item(KindQuery, 31'd5);
    send_item(KindAppend, 31'h7FFFFFFF);
    send_item(KindAppend, 31'd0);
    send_item(KindQuery, 31'd1);
    send_item(KindQuery, 31'd2);
    send_item(KindQuery, 31'h7FFFFFFF);
    send_item(KindQuery, 31'd0);
    send_item(KindAppend, 31'h55555555);
    send_item(KindAppend, 31'h2AAAAAAA);
    send_item(KindQuery, 31'd4);
    drain();
    set_modulus(31'd0);
    send_item(KindAppend, 31'h7FFFFFFF);
    send_item(KindQuery, 31'd1);
    send_item(KindAppend, 31'h7FFFFFFF);
    send_item(KindQuery, 31'd1);
    drain();
    set_modulus(31'd1);
    send_item(KindAppend, 31'h12345678);
    send_item(KindQuery, 31'd3);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 20; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      set_modulus(ph == 5 ? 31'($urandom_range(1, 200)) : moduli[ph]);
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(1)) send_item(KindAppend, rand_operand());
        else send_item(KindQuery, rand_length());
      end
      drain();
    end

    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== suffix_max_append_query_top.f =====
hw/rtl/smaq_pkg.sv
hw/rtl/suffix_max_append_query_top.sv
tb/smaq_checker.sv
tb/testbench.sv
